@@ hdl/m3i_pkg.sv @@
package m3i_pkg;

	// fixed-point format and internal widths
	localparam int FRAC      = 16;
	localparam int DW        = 32;
	localparam int ADJ_W     = 65;                // exact signed cofactor
	localparam int MAG_W     = 64;                // cofactor magnitude
	localparam int DET_W     = 98;                // exact signed determinant
	localparam int DMAG_W    = 97;                // determinant magnitude
	localparam int NUM_W     = MAG_W + 2 * FRAC;  // dividend
	localparam int QB        = 33;                // quotient bits kept before saturation
	localparam int DSH_W     = DMAG_W + QB;       // widest shifted divisor
	localparam int THR_W     = 31;
	localparam int FRONT_LAT = 7;
	localparam int LANE_LAT  = QB + 1;
	localparam int LAT       = FRONT_LAT + LANE_LAT + 1;
	localparam int NE        = 9;

	localparam logic [THR_W-1:0] THR_RST = THR_W'(7);

	// cofactor operand tables: adj[i] = a[CP]*a[CQ] - a[CR]*a[CS]
	localparam int CP [NE] = '{4, 7, 1, 6, 0, 3, 3, 6, 0};
	localparam int CQ [NE] = '{8, 2, 5, 5, 8, 2, 7, 1, 4};
	localparam int CR [NE] = '{7, 1, 4, 3, 6, 0, 6, 0, 3};
	localparam int CS [NE] = '{5, 8, 2, 8, 2, 5, 4, 7, 1};

	typedef logic signed [DW-1:0] ent_t;

	typedef struct packed {
		ent_t a_r0c0; ent_t a_r0c1; ent_t a_r0c2;
		ent_t a_r1c0; ent_t a_r1c1; ent_t a_r1c2;
		ent_t a_r2c0; ent_t a_r2c1; ent_t a_r2c2;
	} mat_in_t;

	typedef struct packed {
		ent_t inv_r0c0; ent_t inv_r0c1; ent_t inv_r0c2;
		ent_t inv_r1c0; ent_t inv_r1c1; ent_t inv_r1c2;
		ent_t inv_r2c0; ent_t inv_r2c1; ent_t inv_r2c2;
		ent_t determinant;
		logic singular;
	} mat_out_t;

	// per-request status shared by all lanes
	typedef struct packed {
		logic              sing;
		ent_t              det_sat;
		logic [DMAG_W-1:0] dmag;
	} ctl_t;

	typedef struct packed {
		logic [NUM_W-1:0] num;
		logic             neg;
	} lane_req_t;

	typedef struct packed {
		logic [QB-1:0] quo;
		logic          ovf;
		logic          neg;
	} lane_res_t;

	// signed 32-bit saturation of a sign and magnitude
	function automatic ent_t sat32(input logic neg, input logic [DMAG_W-1:0] mag);
		logic [DMAG_W-1:0] lim_n;
		logic [DMAG_W-1:0] lim_p;
		ent_t r;
		lim_n = {{(DMAG_W-DW){1'b0}}, 32'h8000_0000};
		lim_p = {{(DMAG_W-DW){1'b0}}, 32'h7FFF_FFFF};
		if (neg) begin
			r = (mag > lim_n) ? ent_t'(32'h8000_0000) : ent_t'(-mag[DW-1:0]);
		end else begin
			r = (mag > lim_p) ? ent_t'(32'h7FFF_FFFF) : ent_t'(mag[DW-1:0]);
		end
		return r;
	endfunction

endpackage

@@ hdl/m3i_front.sv @@
module m3i_front (
	input  logic                       clk,
	input  m3i_pkg::mat_in_t           a,
	input  logic [m3i_pkg::THR_W-1:0]  thr,
	output m3i_pkg::ctl_t              ctl,
	output m3i_pkg::lane_req_t         req [m3i_pkg::NE]
);
	import m3i_pkg::*;

	ent_t                    av [NE];
	logic signed [63:0]      pq_s1 [NE];
	logic signed [63:0]      rs_s1 [NE];
	ent_t                    r0_s1 [3];
	ent_t                    r0_s2 [3];
	logic signed [ADJ_W-1:0] adj_s2 [NE];
	logic signed [ADJ_W-1:0] adj_s3 [NE];
	logic signed [ADJ_W-1:0] adj_s4 [NE];
	logic signed [ADJ_W-1:0] adj_s5 [NE];
	logic signed [64:0]      pl_s3 [3];
	logic signed [64:0]      ph_s3 [3];
	logic signed [DET_W-1:0] prod_s4 [3];
	logic signed [DET_W-1:0] det_s5;
	logic [MAG_W-1:0]        amag_s6 [NE];
	logic                    asgn_s6 [NE];
	logic [DMAG_W-1:0]       dmag_s6;
	logic                    dneg_s6;
	logic [DET_W-1:0]        det_abs;
	logic [DMAG_W-1:0]       lim;

	assign av[0] = a.a_r0c0; assign av[1] = a.a_r0c1; assign av[2] = a.a_r0c2;
	assign av[3] = a.a_r1c0; assign av[4] = a.a_r1c1; assign av[5] = a.a_r1c2;
	assign av[6] = a.a_r2c0; assign av[7] = a.a_r2c1; assign av[8] = a.a_r2c2;

	assign det_abs = det_s5[DET_W-1] ? DET_W'(-det_s5) : DET_W'(det_s5);
	assign lim     = DMAG_W'(thr) << (2 * FRAC);

	// cofactor products, one 32x32 multiply each
	always_ff @(posedge clk) begin
		for (int i = 0; i < NE; i++) begin
			pq_s1[i] <= av[CP[i]] * av[CQ[i]];
			rs_s1[i] <= av[CR[i]] * av[CS[i]];
		end
		for (int j = 0; j < 3; j++) begin
			r0_s1[j] <= av[j];
		end
	end

	// adjugate entries
	always_ff @(posedge clk) begin
		for (int i = 0; i < NE; i++) begin
			adj_s2[i] <= {pq_s1[i][63], pq_s1[i]} - {rs_s1[i][63], rs_s1[i]};
		end
		r0_s2 <= r0_s1;
	end

	// determinant partial products, adjugate split at bit 32
	always_ff @(posedge clk) begin
		for (int j = 0; j < 3; j++) begin
			pl_s3[j] <= $signed({1'b0, adj_s2[3*j][31:0]}) * r0_s2[j];
			ph_s3[j] <= $signed(adj_s2[3*j][ADJ_W-1:32]) * r0_s2[j];
		end
		adj_s3 <= adj_s2;
	end

	// recombine partials
	always_ff @(posedge clk) begin
		for (int j = 0; j < 3; j++) begin
			prod_s4[j] <= ({{(DET_W-65){ph_s3[j][64]}}, ph_s3[j]} <<< 32)
				+ {{(DET_W-65){pl_s3[j][64]}}, pl_s3[j]};
		end
		adj_s4 <= adj_s3;
	end

	// row-0 expansion sum
	always_ff @(posedge clk) begin
		det_s5 <= prod_s4[0] + prod_s4[1] + prod_s4[2];
		adj_s5 <= adj_s4;
	end

	// magnitudes and signs
	always_ff @(posedge clk) begin
		dneg_s6 <= det_s5[DET_W-1];
		dmag_s6 <= det_abs[DMAG_W-1:0];
		for (int i = 0; i < NE; i++) begin
			asgn_s6[i] <= adj_s5[i][ADJ_W-1];
			amag_s6[i] <= adj_s5[i][ADJ_W-1] ? MAG_W'(-adj_s5[i]) : MAG_W'(adj_s5[i]);
		end
	end

	// singular test, determinant output, lane requests
	always_ff @(posedge clk) begin
		ctl.sing    <= (dmag_s6 == '0) || (dmag_s6 < lim);
		ctl.det_sat <= sat32(dneg_s6, dmag_s6 >> (2 * FRAC));
		ctl.dmag    <= dmag_s6;
		for (int i = 0; i < NE; i++) begin
			req[i].num <= {amag_s6[i], {(2*FRAC){1'b0}}};
			req[i].neg <= asgn_s6[i] ^ dneg_s6;
		end
	end

endmodule

@@ hdl/m3i_div_lane.sv @@
module m3i_div_lane (
	input  logic                        clk,
	input  m3i_pkg::lane_req_t          req,
	input  logic [m3i_pkg::DMAG_W-1:0]  dmag,
	output m3i_pkg::lane_res_t          res
);
	import m3i_pkg::*;

	logic [NUM_W-1:0]  rem_s [QB+1];
	logic [DMAG_W-1:0] dvs_s [QB+1];
	logic [QB-1:0]     quo_s [QB+1];
	logic              neg_s [QB+1];
	logic              ovf_s [QB+1];

	// entry stage: quotient too large for the kept bits
	always_ff @(posedge clk) begin
		rem_s[0] <= req.num;
		dvs_s[0] <= dmag;
		quo_s[0] <= '0;
		neg_s[0] <= req.neg;
		ovf_s[0] <= DSH_W'(req.num) >= (DSH_W'(dmag) << QB);
	end

	// one restoring step per stage, MSB first
	for (genvar k = 1; k <= QB; k++) begin : g_step
		localparam int SH = QB - k;
		logic [DSH_W-1:0] dsh;
		logic             take;
		assign dsh  = DSH_W'(dvs_s[k-1]) << SH;
		assign take = DSH_W'(rem_s[k-1]) >= dsh;
		always_ff @(posedge clk) begin
			rem_s[k] <= take ? rem_s[k-1] - dsh[NUM_W-1:0] : rem_s[k-1];
			dvs_s[k] <= dvs_s[k-1];
			quo_s[k] <= quo_s[k-1] | (QB'(take) << SH);
			neg_s[k] <= neg_s[k-1];
			ovf_s[k] <= ovf_s[k-1];
		end
	end

	assign res.quo = quo_s[QB];
	assign res.ovf = ovf_s[QB];
	assign res.neg = neg_s[QB];

endmodule

@@ hdl/m3i_merge.sv @@
module m3i_merge (
	input  logic                clk,
	input  m3i_pkg::lane_res_t  res [m3i_pkg::NE],
	input  m3i_pkg::ctl_t       ctl,
	input  m3i_pkg::mat_in_t    mat,
	output m3i_pkg::mat_out_t   result
);
	import m3i_pkg::*;

	ent_t av  [NE];
	ent_t inv [NE];

	assign av[0] = mat.a_r0c0; assign av[1] = mat.a_r0c1; assign av[2] = mat.a_r0c2;
	assign av[3] = mat.a_r1c0; assign av[4] = mat.a_r1c1; assign av[5] = mat.a_r1c2;
	assign av[6] = mat.a_r2c0; assign av[7] = mat.a_r2c1; assign av[8] = mat.a_r2c2;

	// saturate each lane, or pass the input through when singular
	always_comb begin
		for (int i = 0; i < NE; i++) begin
			if (ctl.sing) begin
				inv[i] = av[i];
			end else begin
				inv[i] = sat32(res[i].neg, res[i].ovf ? {DMAG_W{1'b1}} : DMAG_W'(res[i].quo));
			end
		end
	end

	// output register
	always_ff @(posedge clk) begin
		result.inv_r0c0    <= inv[0];
		result.inv_r0c1    <= inv[1];
		result.inv_r0c2    <= inv[2];
		result.inv_r1c0    <= inv[3];
		result.inv_r1c1    <= inv[4];
		result.inv_r1c2    <= inv[5];
		result.inv_r2c0    <= inv[6];
		result.inv_r2c1    <= inv[7];
		result.inv_r2c2    <= inv[8];
		result.determinant <= ctl.det_sat;
		result.singular    <= ctl.sing;
	end

endmodule

@@ hdl/matrix3x3_inverse_top.sv @@
// channel  | handshake                | payload
// ---------+--------------------------+--------------------------
// request  | start, busy              | a (mat_in_t)
// result   | done (one-cycle strobe)  | result (mat_out_t)
// config   | cfg_valid, cfg_ready     | cfg_data (det_threshold)
//
// One matrix accepted per cycle; busy stays low.
// Pipeline: 7 front stages (cofactors, determinant), 34 stages in each of
// the nine divider lanes (overflow check plus one quotient bit per stage), 1 merge.
// Reset clears the valid pipeline and sets det_threshold to 7.
// The receiver cannot stall: each result shows for exactly one cycle with done.
module matrix3x3_inverse_top (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	output logic                          busy,
	input  m3i_pkg::mat_in_t              a,
	output logic                          done,
	output m3i_pkg::mat_out_t             result,
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [m3i_pkg::THR_W-1:0]     cfg_data
);
	import m3i_pkg::*;

	logic [THR_W-1:0] thr_q;
	logic [LAT-1:0]   vld_q;
	ctl_t             ctl_f;
	ctl_t             ctl_s [LANE_LAT];
	mat_in_t          mat_s [FRONT_LAT+LANE_LAT];
	lane_req_t        req [NE];
	lane_res_t        res [NE];
	logic             accept;

	assign busy      = 1'b0;
	assign cfg_ready = 1'b1;
	assign accept    = start && !busy;
	assign done      = vld_q[LAT-1];

	// threshold register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thr_q <= THR_RST;
		end else if (cfg_valid && cfg_ready) begin
			thr_q <= cfg_data;
		end
	end

	// valid pipeline
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else begin
			vld_q <= {vld_q[LAT-2:0], accept};
		end
	end

	// alignment of status and input matrix to the lane outputs
	always_ff @(posedge clk) begin
		ctl_s[0] <= ctl_f;
		for (int i = 1; i < LANE_LAT; i++) begin
			ctl_s[i] <= ctl_s[i-1];
		end
		mat_s[0] <= a;
		for (int i = 1; i < FRONT_LAT + LANE_LAT; i++) begin
			mat_s[i] <= mat_s[i-1];
		end
	end

	m3i_front u_front (
		.clk (clk),
		.a   (a),
		.thr (thr_q),
		.ctl (ctl_f),
		.req (req)
	);

	for (genvar i = 0; i < NE; i++) begin : g_lane
		m3i_div_lane u_lane (
			.clk  (clk),
			.req  (req[i]),
			.dmag (ctl_f.dmag),
			.res  (res[i])
		);
	end

	m3i_merge u_merge (
		.clk    (clk),
		.res    (res),
		.ctl    (ctl_s[LANE_LAT-1]),
		.mat    (mat_s[FRONT_LAT+LANE_LAT-1]),
		.result (result)
	);

	a_lat_fwd: assert property (@(posedge clk) disable iff (!arst_n)
		accept |-> ##LAT done)
		else $error("accepted request produced no result");
	a_lat_back: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(accept, LAT))
		else $error("result without matching request");
	a_cfg: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_valid && cfg_ready |=> thr_q == $past(cfg_data))
		else $error("threshold write lost");

endmodule
